>>> sv/tclb_pkg.sv
// Shared types and constants for the three-channel LED blinker.
// No dependencies; imported by the controller, the datapath and the top level.
package tclb_pkg;

    localparam int CHANNELS   = 3;
    localparam int TICK_BITS  = 32;
    localparam int LED_OUTS   = 3;
    localparam int LED_N      = (CHANNELS < LED_OUTS) ? CHANNELS : LED_OUTS;
    localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int RATE_COUNT = 5;
    localparam int RATE_W     = 3;
    localparam int CODE_W     = 3;
    localparam int CODE_BASE  = 2;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int DEN_W      = CFG_W + 1;
    localparam int Q_W        = 16;

    localparam int PROD_W     = TICK_BITS + CODE_W;
    localparam int DIV_W      = PROD_W + (PROD_W % 2);
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int DATA_W     = 8;

    localparam logic [CFG_W-1:0] DIVIDER_RESET    = CFG_W'(10000);
    localparam logic [CFG_W-1:0] PHASE_STEP_RESET = CFG_W'(500);

    localparam logic [CFG_ADDR_W-1:0] REG_DIVIDER    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = CFG_ADDR_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } tclb_state_t;

    typedef struct packed {
        logic              accept;
        logic              load;
        logic              step;
        logic              update;
        logic              publish;
        logic [CHAN_W-1:0] chan;
    } tclb_cmd_t;

    typedef struct packed {
        logic out_free;
    } tclb_stat_t;

endpackage

>>> sv/tclb_ctrl.sv
// Sequencer for the LED blinker: accepts a tick, then walks the channels
// through multiply, divide and LED update. Depends on tclb_pkg.
module tclb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tclb_pkg::tclb_stat_t  stat,
    output tclb_pkg::tclb_cmd_t   cmd
);
    import tclb_pkg::*;

    tclb_state_t       state_reg, state_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        chan_next   = chan_reg;
        step_next   = step_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.chan    = chan_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    chan_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_UPDATE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (chan_reg == CHAN_W'(CHANNELS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    chan_next  = chan_reg + CHAN_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_LOAD) && (chan_reg == '0))
        else $error("tick accept did not start at the first channel");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divide step counter out of range");

    a_last_chan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) && (chan_reg == CHAN_W'(CHANNELS - 1))
            |=> (state_reg == ST_DONE))
        else $error("last channel update did not finish the tick");

endmodule

>>> sv/tclb_dpath.sv
// Datapath for the LED blinker: button and channel state, tick counter,
// shared multiply and radix-4 restoring divider, output register. Depends on tclb_pkg.
module tclb_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tclb_pkg::tclb_cmd_t             cmd,
    output tclb_pkg::tclb_stat_t            stat,
    input  logic                            rate_button,
    input  logic                            channel_button,
    input  logic                            shift_button,
    input  logic                            cfg_we,
    input  logic [tclb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tclb_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [tclb_pkg::LED_OUTS-1:0]   m_leds
);
    import tclb_pkg::*;

    logic [CFG_W-1:0]     divider_reg, phase_step_reg;
    logic [RATE_W-1:0]    rate_idx_reg, rate_idx_next;
    logic                 rate_held_reg, rate_held_next;
    logic [CHAN_W-1:0]    sel_reg, sel_next;
    logic                 chan_held_reg, chan_held_next;
    logic                 shift_held_reg, shift_held_next;
    logic [TICK_BITS-1:0] tick_reg;
    logic [Q_W-1:0]       phase_reg [CHANNELS];
    logic [RATE_W-1:0]    crate_reg [CHANNELS];
    logic [Q_W-1:0]       lastq_reg [CHANNELS];
    logic [CHANNELS-1:0]  led_reg;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [Q_W-1:0]       quo_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [LED_OUTS-1:0]  out_leds_reg, leds_view;

    logic [CFG_W-1:0]     div_eff;
    logic [DEN_W-1:0]     den;
    logic                 shift_fire;
    logic [TICK_BITS-1:0] sum;
    logic [CODE_W-1:0]    code;
    logic [PROD_W-1:0]    prod;
    logic [DEN_W:0]       t1, t2;
    logic                 ge1, ge2;
    logic [DEN_W-1:0]     r1, r2;

    assign div_eff = (divider_reg == '0) ? CFG_W'(1) : divider_reg;
    assign den     = {div_eff, 1'b0};

    always_comb begin
        rate_idx_next  = rate_idx_reg;
        rate_held_next = rate_held_reg;
        if (rate_button && !rate_held_reg) begin
            rate_idx_next  = (rate_idx_reg == RATE_W'(RATE_COUNT - 1)) ?
                             '0 : rate_idx_reg + RATE_W'(1);
            rate_held_next = 1'b1;
        end else if (!rate_button) begin
            rate_held_next = 1'b0;
        end

        shift_held_next = shift_button;
        shift_fire      = !shift_button && shift_held_reg;

        sel_next       = sel_reg;
        chan_held_next = chan_held_reg;
        if (channel_button && !chan_held_reg) begin
            sel_next       = (sel_reg == CHAN_W'(CHANNELS - 1)) ?
                             '0 : sel_reg + CHAN_W'(1);
            chan_held_next = 1'b1;
        end else if (!channel_button) begin
            chan_held_next = 1'b0;
        end
    end

    assign sum  = tick_reg + TICK_BITS'(phase_reg[cmd.chan]);
    assign code = CODE_W'(crate_reg[cmd.chan]) + CODE_W'(CODE_BASE);
    assign prod = PROD_W'(sum) * PROD_W'(code);

    always_comb begin
        t1  = {rem_reg, dvd_reg[DIV_W-1]};
        ge1 = (t1 >= {1'b0, den});
        r1  = ge1 ? DEN_W'(t1 - {1'b0, den}) : t1[DEN_W-1:0];
        t2  = {r1, dvd_reg[DIV_W-2]};
        ge2 = (t2 >= {1'b0, den});
        r2  = ge2 ? DEN_W'(t2 - {1'b0, den}) : t2[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg    <= DIVIDER_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
            rate_idx_reg   <= '0;
            rate_held_reg  <= 1'b0;
            sel_reg        <= '0;
            chan_held_reg  <= 1'b0;
            shift_held_reg <= 1'b0;
            tick_reg       <= '0;
            led_reg        <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                phase_reg[c] <= '0;
                crate_reg[c] <= '0;
                lastq_reg[c] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DIVIDER:    divider_reg    <= cfg_wdata;
                    REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                rate_idx_reg   <= rate_idx_next;
                rate_held_reg  <= rate_held_next;
                sel_reg        <= sel_next;
                chan_held_reg  <= chan_held_next;
                shift_held_reg <= shift_held_next;
                tick_reg       <= tick_reg + TICK_BITS'(1);
                for (int c = 0; c < CHANNELS; c++) begin
                    if (shift_fire && (sel_reg == CHAN_W'(c))) begin
                        phase_reg[c] <= phase_reg[c] + phase_step_reg;
                    end
                    if (sel_next == CHAN_W'(c)) begin
                        crate_reg[c] <= rate_idx_next;
                    end
                end
            end
            if (cmd.update) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if ((cmd.chan == CHAN_W'(c)) && (quo_reg != lastq_reg[c])) begin
                        led_reg[c]   <= ~led_reg[c];
                        lastq_reg[c] <= quo_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dvd_reg <= DIV_W'(prod);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.step) begin
            dvd_reg <= {dvd_reg[DIV_W-3:0], 2'b00};
            rem_reg <= r2;
            quo_reg <= {quo_reg[Q_W-3:0], ge1, ge2};
        end
    end

    always_comb begin
        leds_view = '0;
        for (int i = 0; i < LED_N; i++) begin
            leds_view[i] = led_reg[i];
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_leds_reg <= leds_view;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_leds   = out_leds_reg;

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!out_valid_reg || m_tready))
        else $error("result written over a word not yet taken");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (rem_reg < den))
        else $error("divider remainder not below divisor");

endmodule

>>> sv/three_channel_led_blinker.sv
// Top level of the three-channel LED blinker: stream ports, config port,
// controller and datapath. Depends on tclb_pkg, tclb_ctrl and tclb_dpath.
//
// Each accepted input word is one tick. The block accepts the tick, then for
// each channel forms (tick + phase) * code, runs the shared restoring divider
// at two quotient bits per cycle over the 36-bit dividend built from the
// 35-bit product, and updates the LED; it then publishes the LED word. The
// divider is shared by the channels in turn, so one tick is processed at a
// time. The result word sits in an output register, so the next tick is
// accepted while the previous LED word waits.
module three_channel_led_blinker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tclb_pkg::DATA_W-1:0]     s_tdata,  // rate_button, channel_button, shift_button
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tclb_pkg::DATA_W-1:0]     m_tdata,  // led_green, led_red, led_blue
    input  logic                            cfg_we,
    input  logic [tclb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tclb_pkg::CFG_W-1:0]      cfg_wdata
);
    import tclb_pkg::*;

    tclb_cmd_t           cmd;
    tclb_stat_t          stat;
    logic [LED_OUTS-1:0] leds;

    tclb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tclb_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .rate_button    (s_tdata[0]),
        .channel_button (s_tdata[1]),
        .shift_button   (s_tdata[2]),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_leds         (leds)
    );

    assign m_tdata = {{(DATA_W - LED_OUTS){1'b0}}, leds};

endmodule
